/* design/cbse_pkg.sv */
`timescale 1ns / 1ps
// Shared codes for the cubic Bezier split/evaluate core.
// No dependencies.
package cbse_pkg;

	localparam int KIND_W    = 3;
	localparam int NUM_KINDS = 7;

	// Result item kinds, in emission order
	typedef enum logic [KIND_W-1:0] {
		KIND_P01   = 3'd0,
		KIND_P12   = 3'd1,
		KIND_P23   = 3'd2,
		KIND_P012  = 3'd3,
		KIND_P123  = 3'd4,
		KIND_CURVE = 3'd5,
		KIND_VEL   = 3'd6
	} kind_t;

endpackage

/* design/cbse_job_if.sv */
`timescale 1ns / 1ps
// Input channel: span, split time and four control points.
// Depends on nothing but COORD_WIDTH.
interface cbse_job_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] start_time;
	logic signed [COORD_WIDTH-1:0] end_time;
	logic signed [COORD_WIDTH-1:0] eval_time;
	logic signed [COORD_WIDTH-1:0] p0_x;
	logic signed [COORD_WIDTH-1:0] p0_y;
	logic signed [COORD_WIDTH-1:0] p1_x;
	logic signed [COORD_WIDTH-1:0] p1_y;
	logic signed [COORD_WIDTH-1:0] p2_x;
	logic signed [COORD_WIDTH-1:0] p2_y;
	logic signed [COORD_WIDTH-1:0] p3_x;
	logic signed [COORD_WIDTH-1:0] p3_y;

	modport source (
		output valid, start_time, end_time, eval_time,
		output p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
		input  ready
	);
	modport sink (
		input  valid, start_time, end_time, eval_time,
		input  p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
		output ready
	);
endinterface

/* design/cbse_res_if.sv */
`timescale 1ns / 1ps
// Result channel: one point or velocity per transfer.
// Depends on cbse_pkg for the kind code.
interface cbse_res_if import cbse_pkg::*; #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	kind_t                         point_kind;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic                          zero_span;
	logic                          last_item;

	modport source (
		output valid, point_kind, out_x, out_y, zero_span, last_item,
		input  ready
	);
	modport sink (
		input  valid, point_kind, out_x, out_y, zero_span, last_item,
		output ready
	);
endinterface

/* design/cbse_div_pipe.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: floor(num * 2^(F+1) / den), two quotient bits
// per stage, with an overflow flag when the quotient needs more than W bits.
module cbse_div_pipe #(
	parameter int W         = 32,
	parameter int NUM_WIDTH = 32,
	parameter int F         = 16,
	parameter int LANES     = 1,
	parameter int PW        = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic [LANES-1:0][NUM_WIDTH-1:0]   num,
	input  logic [W-1:0]                      den,
	input  logic [PW-1:0]                     in_pay,
	output logic                              out_valid,
	output logic [LANES-1:0][W-1:0]           quo,
	output logic [LANES-1:0]                  ovf,
	output logic [PW-1:0]                     out_pay
);
	localparam int STEPS = 2;
	localparam int NS    = (W + STEPS - 1) / STEPS;
	localparam int DW    = NUM_WIDTH + F + 1;
	localparam int CW    = ((DW > 2 * W) ? DW : 2 * W) + 1;

	logic [LANES-1:0][W-1:0] rem_s [NS+1];
	logic [LANES-1:0][W-1:0] quo_s [NS+1];
	logic [LANES-1:0]        ovf_s [NS+1];
	logic [W-1:0]            den_s [NS+1];
	logic [PW-1:0]           pay_s [NS+1];
	logic                    vld_s [NS+1];

	logic [LANES-1:0][W-1:0] rem_c0, quo_c0;
	logic [LANES-1:0]        ovf_c0;

	// entry: overflow test, top part of the dividend as first remainder
	always_comb begin
		logic [DW-1:0] nfull;
		logic [DW-1:0] nhi;
		for (int ln = 0; ln < LANES; ln++) begin
			nfull      = {num[ln], {(F+1){1'b0}}};
			nhi        = nfull >> W;
			ovf_c0[ln] = CW'(nfull) >= CW'({den, {W{1'b0}}});
			rem_c0[ln] = nhi[W-1:0];
			quo_c0[ln] = nfull[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= rem_c0;
			quo_s[0] <= quo_c0;
			ovf_s[0] <= ovf_c0;
			den_s[0] <= den;
			pay_s[0] <= in_pay;
		end
	end

	for (genvar j = 1; j <= NS; j++) begin : g_stage
		logic [LANES-1:0][W-1:0] rem_c, quo_c;

		always_comb begin
			logic [W-1:0] r;
			logic [W-1:0] qq;
			logic [W:0]   r2;
			for (int ln = 0; ln < LANES; ln++) begin
				r  = rem_s[j-1][ln];
				qq = quo_s[j-1][ln];
				for (int i = 0; i < STEPS; i++) begin
					if ((j - 1) * STEPS + i < W) begin
						r2 = {r, qq[W-1]};
						qq = {qq[W-2:0], 1'b0};
						if (r2 >= {1'b0, den_s[j-1]}) begin
							r     = W'(r2 - {1'b0, den_s[j-1]});
							qq[0] = 1'b1;
						end else begin
							r = r2[W-1:0];
						end
					end
				end
				rem_c[ln] = r;
				quo_c[ln] = qq;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j] <= rem_c;
				quo_s[j] <= quo_c;
				ovf_s[j] <= ovf_s[j-1];
				den_s[j] <= den_s[j-1];
				pay_s[j] <= pay_s[j-1];
			end
		end
	end

	assign out_valid = vld_s[NS];
	assign quo       = quo_s[NS];
	assign ovf       = ovf_s[NS];
	assign out_pay   = pay_s[NS];

endmodule

/* design/cubic_bezier_split_eval_core.sv */
`timescale 1ns / 1ps
// Cubic Bezier De Casteljau split and evaluation core, top level.
// Depends on cbse_pkg, cbse_job_if, cbse_res_if and cbse_div_pipe.
//
// Usage:
//  job: one transfer carries the span start_time..end_time, the split time
//   eval_time and control points P0..P3, all signed fixed point.
//  res: each job gives seven transfers in order p01, p12, p23, p012, p123,
//   curve point, velocity; the last carries last_item. A job whose span is
//   zero gives a single transfer with zero_span and last_item set and zero
//   coordinates.
//  Pipeline: job fields pass s1, s2, the span-fraction divider, s3, the
//   De Casteljau levels, the velocity divider, sv and the output register;
//   the two dividers resolve two quotient bits per stage.
//  Throughput: a job may enter every cycle the pipe moves; results leave one
//   per cycle while res.ready is high, so a sustained stream is set by the
//   result channel, which takes seven transfers per job of nonzero span.
//  Stall: a single advance enable moves the whole pipe. While the output
//   register still holds results and the last stage is full, the pipe and
//   job.ready hold; nothing is dropped or repeated.
//  Reset: clears valid bits and the output register's valid, zero and kind state; no clearing pass.
module cubic_bezier_split_eval_core import cbse_pkg::*; #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	cbse_job_if.sink  job,
	cbse_res_if.source res
);
	localparam int W  = COORD_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int AW = 2 * W + F + 2;

	localparam logic signed [W-1:0]  SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  SMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [AW-1:0] AMAX = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [AW-1:0] AMIN = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic [AW-1:0]        HALF = AW'(1) << (F - 1);

	// points per axis: 0..3 control points, 4..6 first level, 7..8 second, 9 curve
	typedef logic [1:0][9:0][W-1:0] pts_t;

	typedef struct packed {
		logic         zero;
		logic         dt_neg;
		logic [W-1:0] dt_mag;
		logic [1:0]   neg;
		pts_t         pts;
	} car_t;

	typedef struct packed {
		logic         zero;
		logic         dt_neg;
		logic [W-1:0] dt_mag;
		logic [W-1:0] b;
		pts_t         pts;
	} lvl_t;

	function automatic logic [W-1:0] abs_w(input logic [W:0] v);
		logic [W:0] n;
		n = v[W] ? (~v + 1'b1) : v;
		return n[W-1:0];
	endfunction

	// divider quotient (one extra bit) -> rounded, signed, saturated value
	function automatic logic [W-1:0] quot_val(input logic [W-1:0] q, input logic ov,
			input logic neg);
		logic [W:0]   s;
		logic [W-1:0] m;
		s = {1'b0, q} + 1'b1;
		m = s[W:1];
		if (ov)
			return neg ? SMIN : SMAX;
		else if (neg)
			return ~m + 1'b1;
		else if (m[W-1])
			return SMAX;
		else
			return m;
	endfunction

	function automatic logic signed [2*W:0] mul_bd(input logic [W-1:0] b,
			input logic [W:0] d);
		return $signed({{(W+1){b[W-1]}}, b}) * $signed({{W{d[W]}}, d});
	endfunction

	// p + round(prod / 2^F), ties away from zero, saturated
	function automatic logic [W-1:0] mix_out(input logic signed [2*W:0] prod,
			input logic [W-1:0] p);
		logic signed [AW-1:0] pe, xe, acc, sh;
		pe  = AW'($signed(p));
		xe  = AW'(prod);
		acc = xe + (pe <<< F) + HALF - {{(AW-1){1'b0}}, prod[2*W]};
		sh  = acc >>> F;
		if (sh > AMAX)
			return SMAX;
		else if (sh < AMIN)
			return SMIN;
		else
			return sh[W-1:0];
	endfunction

	logic adv;

	// ---- s1: span differences ----
	logic         v_s1;
	logic [W:0]   dt_s1, nb_s1;
	pts_t         pts_s1;
	pts_t         pts_in;

	always_comb begin
		pts_in       = '0;
		pts_in[0][0] = job.p0_x;
		pts_in[1][0] = job.p0_y;
		pts_in[0][1] = job.p1_x;
		pts_in[1][1] = job.p1_y;
		pts_in[0][2] = job.p2_x;
		pts_in[1][2] = job.p2_y;
		pts_in[0][3] = job.p3_x;
		pts_in[1][3] = job.p3_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= job.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dt_s1  <= {job.end_time[W-1], job.end_time} -
				{job.start_time[W-1], job.start_time};
			nb_s1  <= {job.eval_time[W-1], job.eval_time} -
				{job.start_time[W-1], job.start_time};
			pts_s1 <= pts_in;
		end
	end

	// ---- s2: magnitudes and sign of the fraction ----
	logic            v_s2;
	car_t            car_s2;
	logic [0:0][W-1:0] numb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s2.zero   <= (dt_s1 == '0);
			car_s2.dt_neg <= dt_s1[W];
			car_s2.dt_mag <= abs_w(dt_s1);
			car_s2.neg    <= {1'b0, nb_s1[W] ^ dt_s1[W]};
			car_s2.pts    <= pts_s1;
			numb_s2[0]    <= abs_w(nb_s1);
		end
	end

	// ---- fraction b = (t - t0) / (t1 - t0) ----
	logic              bq_v;
	logic [0:0][W-1:0] bq;
	logic [0:0]        bq_ovf;
	logic [$bits(car_t)-1:0] bq_pay;
	car_t              bcar;

	cbse_div_pipe #(
		.W(W), .NUM_WIDTH(W), .F(F), .LANES(1), .PW($bits(car_t))
	) u_div_b (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_s2),
		.num(numb_s2), .den(car_s2.dt_mag), .in_pay(car_s2),
		.out_valid(bq_v), .quo(bq), .ovf(bq_ovf), .out_pay(bq_pay)
	);

	assign bcar = car_t'(bq_pay);

	// ---- s3: b as signed fixed point ----
	logic v_s3;
	lvl_t lv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= bq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lv_s3.zero   <= bcar.zero;
			lv_s3.dt_neg <= bcar.dt_neg;
			lv_s3.dt_mag <= bcar.dt_mag;
			lv_s3.b      <= quot_val(bq[0], bq_ovf[0], bcar.neg[0]);
			lv_s3.pts    <= bcar.pts;
		end
	end

	// ---- De Casteljau levels: difference, product, round and add ----
	lvl_t lv_in [3];
	logic vin   [3];
	lvl_t lv_sa [3];
	lvl_t lv_sb [3];
	lvl_t lv_sc [3];
	logic v_sa  [3];
	logic v_sb  [3];
	logic v_sc  [3];
	logic [W:0]          d_sa    [3][2][3];
	logic signed [2*W:0] prod_sb [3][2][3];

	assign lv_in[0] = lv_s3;
	assign vin[0]   = v_s3;

	for (genvar l = 1; l < 3; l++) begin : g_link
		assign lv_in[l] = lv_sc[l-1];
		assign vin[l]   = v_sc[l-1];
	end

	for (genvar l = 0; l < 3; l++) begin : g_lvl
		localparam int NM = 3 - l;
		localparam int IB = 4 * l - (l * (l - 1)) / 2;
		localparam int OB = IB + NM + 1;

		lvl_t sc_c;

		always_comb begin
			sc_c = lv_sb[l];
			for (int ax = 0; ax < 2; ax++) begin
				for (int k = 0; k < NM; k++) begin
					sc_c.pts[ax][OB+k] = mix_out(prod_sb[l][ax][k],
						lv_sb[l].pts[ax][IB+k]);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sa[l] <= 1'b0;
				v_sb[l] <= 1'b0;
				v_sc[l] <= 1'b0;
			end else if (adv) begin
				v_sa[l] <= vin[l];
				v_sb[l] <= v_sa[l];
				v_sc[l] <= v_sb[l];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lv_sa[l] <= lv_in[l];
				lv_sb[l] <= lv_sa[l];
				lv_sc[l] <= sc_c;
				for (int ax = 0; ax < 2; ax++) begin
					for (int k = 0; k < NM; k++) begin
						d_sa[l][ax][k] <=
							{lv_in[l].pts[ax][IB+k+1][W-1], lv_in[l].pts[ax][IB+k+1]} -
							{lv_in[l].pts[ax][IB+k][W-1], lv_in[l].pts[ax][IB+k]};
						prod_sb[l][ax][k] <= mul_bd(lv_sa[l].b, d_sa[l][ax][k]);
					end
				end
			end
		end
	end

	// ---- velocity operand, alongside the last level: 3 * |p123 - p012| ----
	logic [W:0]   vdx_sa  [2];
	logic [W-1:0] vmag_sb [2];
	logic [W+1:0] v3_sc   [2];
	logic [1:0]   vneg_sb, vneg_sc;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ax = 0; ax < 2; ax++) begin
				vdx_sa[ax]  <= {lv_in[2].pts[ax][8][W-1], lv_in[2].pts[ax][8]} -
					{lv_in[2].pts[ax][7][W-1], lv_in[2].pts[ax][7]};
				vmag_sb[ax] <= abs_w(vdx_sa[ax]);
				vneg_sb[ax] <= vdx_sa[ax][W] ^ lv_sa[2].dt_neg;
				v3_sc[ax]   <= {2'b00, vmag_sb[ax]} + {1'b0, vmag_sb[ax], 1'b0};
			end
			vneg_sc <= vneg_sb;
		end
	end

	logic [1:0][W+1:0] vnum;
	car_t              vcar_in;

	always_comb begin
		vnum[0]        = v3_sc[0];
		vnum[1]        = v3_sc[1];
		vcar_in.zero   = lv_sc[2].zero;
		vcar_in.dt_neg = lv_sc[2].dt_neg;
		vcar_in.dt_mag = lv_sc[2].dt_mag;
		vcar_in.neg    = vneg_sc;
		vcar_in.pts    = lv_sc[2].pts;
	end

	logic              vq_v;
	logic [1:0][W-1:0] vq;
	logic [1:0]        vq_ovf;
	logic [$bits(car_t)-1:0] vq_pay;
	car_t              vcar;

	cbse_div_pipe #(
		.W(W), .NUM_WIDTH(W + 2), .F(F), .LANES(2), .PW($bits(car_t))
	) u_div_v (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_sc[2]),
		.num(vnum), .den(lv_sc[2].dt_mag), .in_pay(vcar_in),
		.out_valid(vq_v), .quo(vq), .ovf(vq_ovf), .out_pay(vq_pay)
	);

	assign vcar = car_t'(vq_pay);

	// ---- sv: all seven results gathered ----
	logic              v_sv;
	logic              zero_sv;
	logic [1:0][W-1:0] fin_sv [NUM_KINDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sv <= 1'b0;
		end else if (adv) begin
			v_sv <= vq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_sv <= vcar.zero;
			for (int k = 0; k < NUM_KINDS - 1; k++) begin
				fin_sv[k][0] <= vcar.pts[0][4+k];
				fin_sv[k][1] <= vcar.pts[1][4+k];
			end
			for (int ax = 0; ax < 2; ax++) begin
				fin_sv[NUM_KINDS-1][ax] <= quot_val(vq[ax], vq_ovf[ax], vcar.neg[ax]);
			end
		end
	end

	// ---- output register: shifts one result out per transfer ----
	logic              ser_v_q;
	logic              zero_q;
	kind_t             kind_q;
	logic [1:0][W-1:0] res_q [NUM_KINDS];
	logic              take, done, ser_load;

	assign take     = ser_v_q && res.ready;
	assign done     = take && res.last_item;
	assign ser_load = v_sv && (!ser_v_q || done);
	assign adv      = !v_sv || ser_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			zero_q  <= 1'b0;
			kind_q  <= KIND_P01;
		end else if (ser_load) begin
			ser_v_q <= 1'b1;
			zero_q  <= zero_sv;
			kind_q  <= KIND_P01;
		end else if (done) begin
			ser_v_q <= 1'b0;
		end else if (take) begin
			kind_q <= kind_t'(kind_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			res_q <= fin_sv;
		end else if (take) begin
			for (int k = 0; k < NUM_KINDS - 1; k++) begin
				res_q[k] <= res_q[k+1];
			end
		end
	end

	assign job.ready      = adv;
	assign res.valid      = ser_v_q;
	assign res.point_kind = kind_q;
	assign res.out_x      = zero_q ? '0 : res_q[0][0];
	assign res.out_y      = zero_q ? '0 : res_q[0][1];
	assign res.zero_span  = zero_q;
	assign res.last_item  = zero_q || (kind_q == KIND_VEL);

	// ---- checks ----
	a_kind_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && !res.last_item |=> kind_q == kind_t'($past(kind_q) + 3'd1))
		else $error("result kind did not advance by one");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_sv && !adv |=> v_sv && $stable(zero_sv) && $stable(fin_sv[NUM_KINDS-1]))
		else $error("last stage changed while held");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ser_load |=> !ser_v_q)
		else $error("output still valid after final transfer");

endmodule

/* verif/cubic_bezier_split_eval_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for cubic_bezier_split_eval_core: random and corner jobs
// in, every result point checked against an in-bench fixed-point predictor.
// Depends on cbse_pkg, cbse_job_if, cbse_res_if and the core itself.

// Holds the expected result points and compares each transfer against them
class bezier_scoreboard;
	typedef struct packed {
		cbse_pkg::kind_t kind;
		logic [31:0]     x;
		logic [31:0]     y;
		logic            zs;
		logic            last;
	} point_t;

	point_t pending[$];
	int     mismatches;
	int     jobs_seen;
	int     points_seen;
	int     zero_spans;

	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;
	localparam longint CAP  = 64'sd4294967296;

	function longint clip(longint v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	function longint magn(longint v);
		return v < 0 ? -v : v;
	endfunction

	function longint apply_sign(bit neg, longint m);
		if (neg) return (m > -SMIN) ? SMIN : -m;
		return (m > SMAX) ? SMAX : m;
	endfunction

	// round(num * 2^16 / den), ties up; CAP when it overflows
	function longint frac_div(longint num, longint den);
		logic [127:0] q;
		q = (({64'd0, num} << 17) / den + 1) >> 1;
		if (q >= CAP) return CAP;
		return longint'(q);
	endfunction

	// round(x * y / 2^16), ties up; CAP when it overflows
	function longint frac_mul(longint x, longint y);
		logic [127:0] p;
		p = (128'(x) * 128'(y) + 128'h8000) >> 16;
		if (p >= CAP) return CAP;
		return longint'(p);
	endfunction

	function longint lerp(longint p, longint q, longint b);
		longint d, t;
		d = q - p;
		t = frac_mul(magn(b), magn(d));
		if ((b < 0) != (d < 0)) t = -t;
		return clip(p + t);
	endfunction

	// Work out the seven points (or the zero-span marker) for one job
	function void note_job(logic signed [31:0] f [11]);
		longint t0, t1, t, dt, nb, b, dx, dy;
		longint px[4], py[4], rx[7], ry[7];
		point_t e;
		jobs_seen++;
		t0 = f[0]; t1 = f[1]; t = f[2];
		dt = t1 - t0; nb = t - t0;
		if (dt == 0) begin
			zero_spans++;
			e.kind = cbse_pkg::KIND_P01; e.x = 0; e.y = 0; e.zs = 1; e.last = 1;
			pending.push_back(e);
			return;
		end
		for (int k = 0; k < 4; k++) begin
			px[k] = f[3 + 2 * k];
			py[k] = f[4 + 2 * k];
		end
		b = apply_sign((nb < 0) != (dt < 0), frac_div(magn(nb), magn(dt)));
		for (int k = 0; k < 3; k++) begin
			rx[k] = lerp(px[k], px[k + 1], b);
			ry[k] = lerp(py[k], py[k + 1], b);
		end
		rx[3] = lerp(rx[0], rx[1], b); ry[3] = lerp(ry[0], ry[1], b);
		rx[4] = lerp(rx[1], rx[2], b); ry[4] = lerp(ry[1], ry[2], b);
		rx[5] = lerp(rx[3], rx[4], b); ry[5] = lerp(ry[3], ry[4], b);
		dx = rx[4] - rx[3]; dy = ry[4] - ry[3];
		rx[6] = apply_sign((dx < 0) != (dt < 0), frac_div(3 * magn(dx), magn(dt)));
		ry[6] = apply_sign((dy < 0) != (dt < 0), frac_div(3 * magn(dy), magn(dt)));
		for (int k = 0; k < 7; k++) begin
			e.kind = cbse_pkg::kind_t'(k);
			e.x = rx[k][31:0]; e.y = ry[k][31:0];
			e.zs = 0; e.last = (k == 6);
			pending.push_back(e);
		end
	endfunction

	task report(string what);
		mismatches++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	task check_point(point_t got);
		point_t e;
		points_seen++;
		if (pending.size() == 0) begin
			report($sformatf("unexpected point kind %0d", got.kind));
			return;
		end
		e = pending.pop_front();
		if (got.kind !== e.kind) report($sformatf("kind %0d, want %0d", got.kind, e.kind));
		if (got.x !== e.x) report($sformatf("kind %0d x %h, want %h", e.kind, got.x, e.x));
		if (got.y !== e.y) report($sformatf("kind %0d y %h, want %h", e.kind, got.y, e.y));
		if (got.zs !== e.zs) report($sformatf("zero_span %b, want %b", got.zs, e.zs));
		if (got.last !== e.last) report($sformatf("last_item %b, want %b", got.last, e.last));
	endtask
endclass

module cubic_bezier_split_eval_core_tb;
	import cbse_pkg::*;

	localparam int ONE       = 32'h0001_0000;  // 1.0 in Q16.16
	localparam int WATCHDOG  = 5000;           // idle cycles before giving up
	localparam int DRAIN     = 100;            // wait after the last expected point

	logic clk;
	logic arst_n;

	cbse_job_if #(.COORD_WIDTH(32)) job ();
	cbse_res_if #(.COORD_WIDTH(32)) res ();

	cubic_bezier_split_eval_core #(
		.COORD_WIDTH  (32),
		.FRACTION_BITS(16)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.job   (job.sink),
		.res   (res.source)
	);

	bezier_scoreboard sb;

	// Idle rates in percent for the sender and the receiver
	int send_idle;
	int recv_stall;
	int idle_cycles;

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	// Receiver: random stalls, one ready assignment per edge, checks on transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready)
				sb.check_point({res.point_kind, res.out_x, res.out_y,
					res.zero_span, res.last_item});
			res.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// Watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((job.valid && job.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired, %0d points outstanding", sb.pending.size());
			$display("cubic_bezier_split_eval_core_tb NOT OK");
			$finish;
		end
	end

	// One job: optional idle gap, then hold valid until the transfer;
	// valid stays high afterwards so a following job can go back to back
	task send_job(logic signed [31:0] f [11]);
		while ($urandom_range(99) < send_idle) begin
			job.valid <= 1'b0;
			@(posedge clk);
		end
		job.valid      <= 1'b1;
		job.start_time <= f[0];
		job.end_time   <= f[1];
		job.eval_time  <= f[2];
		job.p0_x <= f[3]; job.p0_y <= f[4];
		job.p1_x <= f[5]; job.p1_y <= f[6];
		job.p2_x <= f[7]; job.p2_y <= f[8];
		job.p3_x <= f[9]; job.p3_y <= f[10];
		do @(posedge clk); while (!job.ready);
		sb.note_job(f);
	endtask

	// Drop valid right after the last transfer of a burst
	task stop_sending();
		job.valid <= 1'b0;
	endtask

	// Random field: mostly modest coordinates, sometimes full-scale
	function logic signed [31:0] rnd_field();
		case ($urandom_range(3))
			0:       return $urandom;
			1:       return $signed($urandom_range(32'h0006_0000)) - 32'sh0003_0000;
			default: return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
		endcase
	endfunction

	task send_random();
		logic signed [31:0] f [11];
		foreach (f[i]) f[i] = rnd_field();
		// Keep most spans sane and t inside or near them
		if ($urandom_range(3) != 0) begin
			f[0] = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
			f[1] = f[0] + $urandom_range(1, 32'h0004_0000) * ($urandom_range(1) ? 1 : -1);
			f[2] = f[0] + $signed($urandom_range(32'h0006_0000)) - 32'sh0001_0000;
		end
		if ($urandom_range(19) == 0) f[1] = f[0];
		send_job(f);
	endtask

	task wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task directed();
		logic signed [31:0] f [11];
		// Unit span, t = 0.5, simple square of control points
		f = '{0, ONE, ONE / 2, 0, 0, ONE, 0, ONE, ONE, 0, ONE};
		send_job(f);
		// t at both ends of the span, and a reversed span
		f[2] = 0;   send_job(f);
		f[2] = ONE; send_job(f);
		f = '{ONE, 0, ONE / 4, 0, 0, ONE, 0, ONE, ONE, 0, ONE};
		send_job(f);
		// Zero span, first with small fields, then with the other fields at extremes
		f = '{32'sh7fff_ffff, 32'sh7fff_ffff, 0, -1, 1, 0, 0, 0, 0, 0, 0};
		send_job(f);
		f = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000};
		send_job(f);
		// Extreme points, t far outside a tiny span so b saturates
		f = '{0, 1, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000};
		send_job(f);
		f[2] = 32'sh8000_0000; send_job(f);
		// Widest span, t at the other extreme
		f = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
			-1, -1, 32'sh7fff_ffff, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 1};
		send_job(f);
		// All-ones and all-zero patterns over every field but end_time
		f = '{-1, 0, -1, -1, -1, -1, -1, -1, -1, -1, -1};
		send_job(f);
		f = '{0, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_job(f);
		// Velocity overflow: huge point swing over a tiny span
		f = '{0, 1, 0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0};
		send_job(f);
		// Rounding ties: span of three units, t one third
		f = '{0, 3 * ONE, ONE, 1, 3, 2, 5, 7, 9, 11, 13};
		send_job(f);
	endtask

	task random_phase(int n, int s_idle, int r_stall);
		send_idle  = s_idle;
		recv_stall = r_stall;
		repeat (n) send_random();
	endtask

	initial begin
		sb          = new();
		send_idle   = 0;
		recv_stall  = 0;
		arst_n      = 1'b0;
		job.valid   = 1'b0;
		job.start_time = '0; job.end_time = '0; job.eval_time = '0;
		job.p0_x = '0; job.p0_y = '0; job.p1_x = '0; job.p1_y = '0;
		job.p2_x = '0; job.p2_y = '0; job.p3_x = '0; job.p3_y = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();
		stop_sending();
		// Hold the sender back until the pipe has fully drained
		wait_drained();
		random_phase(50, 0, 0);
		random_phase(50, 46, 0);
		random_phase(50, 0, 46);
		random_phase(50, 36, 36);
		stop_sending();

		wait_drained();
		repeat (DRAIN) @(posedge clk);

		$display("%0d jobs (%0d zero-span) gave %0d result points",
			sb.jobs_seen, sb.zero_spans, sb.points_seen);
		$display("across free-running, sender-idle, receiver-stall and mixed phases");
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("cubic_bezier_split_eval_core_tb OK");
		else
			$display("cubic_bezier_split_eval_core_tb NOT OK");
		$finish;
	end
endmodule

/* filelist.f */
design/cbse_pkg.sv
design/cbse_job_if.sv
design/cbse_res_if.sv
design/cbse_div_pipe.sv
design/cubic_bezier_split_eval_core.sv
verif/cubic_bezier_split_eval_core_tb.sv
